@@ hdl/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg: periodic timer table shared types
// Item and result structs, operation and result codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned CfgW = 5;
  localparam logic [CfgW-1:0] UseReset = 5'd16;

  typedef enum logic [2:0] {
    K_INSERT = 3'd0, K_DELETE = 3'd1, K_TICK = 3'd2, K_LOOKUP = 3'd3,
    K_GETCTX = 3'd4, K_SETCNT = 3'd5, K_RSTCNT = 3'd6, K_NONE = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    R_INSERTED = 4'd0, R_INSFAIL = 4'd1, R_DELETED = 4'd2, R_OVERRUN = 4'd3,
    R_TIMEOUT = 4'd4, R_FOUND = 4'd5, R_NOTFOUND = 4'd6, R_CONTEXT = 4'd7,
    R_DONE = 4'd8
  } code_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] event_id;
    logic [3:0]  slot;
    logic [31:0] count;
    logic [31:0] elapsed;
    logic [31:0] context_req;
  } item_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [3:0]  slot_res;
    logic [15:0] event_id_res;
    logic [31:0] context_res;
    logic        last;
  } result_t;

endpackage

@@ hdl/periodic_timer_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_unit: periodic timer slot table
// Insert, lookup and tick scan up to slots_in_use slots; the other operations
// touch a single slot. A tick emits an extra result per overrun or timeout.
// One item is worked on at a time, with up to two more waiting in the queue;
// the engine walks one slot per cycle, pausing while it emits tick results.
// Reset: synchronous; all slots free, slots_in_use back to 16.
// ----------------------------------------------------------------------------
module periodic_timer_table_unit #(
  parameter int unsigned SLOTS = ptt_pkg::SlotsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ptt_pkg::item_t           in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output ptt_pkg::result_t         out_data,
  // configuration write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ptt_pkg::CfgW-1:0] cfg_data
);

  logic [ptt_pkg::CfgW-1:0] slots_in_use;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;
  ptt_pkg::item_t q_head;
  logic           eng_busy;

  // front: accept into the queue whenever it has room
  assign in_stall  = q_full;
  // register only changes while nothing is queued or being worked on
  assign cfg_ready = !eng_busy && !q_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= ptt_pkg::UseReset;
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  ptt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (in_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // back: sequencer, one slot per cycle between emitted results, owns the output register
  ptt_engine #(.SLOTS(SLOTS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .slots_in_use (slots_in_use),
    .avail        (q_avail),
    .head         (q_head),
    .pop          (q_pop),
    .res_valid    (out_valid),
    .res          (out_data),
    .res_stall    (out_stall),
    .busy         (eng_busy)
  );

endmodule

@@ hdl/ptt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_queue: two-entry item queue
// Decouples the accepting front from the executing back.
// ----------------------------------------------------------------------------
module ptt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ptt_pkg::item_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output ptt_pkg::item_t  head
);

  ptt_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/ptt_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_engine: slot table and operation sequencer
// Walks the slots one per cycle for searches and ticks, pausing to emit tick results.
// ----------------------------------------------------------------------------
module ptt_engine #(
  parameter int unsigned SLOTS = ptt_pkg::SlotsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ptt_pkg::CfgW-1:0] slots_in_use,
  input  logic                  avail,
  input  ptt_pkg::item_t        head,
  output logic                  pop,
  output logic                  res_valid,
  output ptt_pkg::result_t      res,
  input  logic                  res_stall,
  output logic                  busy
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EMIT, S_OVR, S_TMO, S_DONE
  } state_t;

  state_t         state;
  ptt_pkg::item_t op;
  logic [SLOTS-1:0] active;
  logic [15:0] owner   [SLOTS];
  logic [31:0] reload  [SLOTS];
  logic [31:0] current [SLOTS];
  logic [31:0] ctxw    [SLOTS];
  logic [CW-1:0] idx;
  logic [CW-1:0] used;
  logic          dup;
  logic          have_free;
  logic [IW-1:0] free_idx;
  ptt_pkg::result_t pend;

  logic [CW-1:0] cfg_ext;
  logic [IW-1:0] ix;
  logic [IW-1:0] sx;
  logic          sok;
  logic          out_free;
  logic          res_load;
  logic [31:0]   c;

  assign cfg_ext  = CW'(slots_in_use);
  assign ix       = idx[IW-1:0];
  assign sx       = IW'(op.slot);
  assign sok      = ({1'b0, op.slot} < 5'(used)) && (32'(op.slot) < SLOTS);
  assign out_free = !res_valid || !res_stall;
  // output register loads a new result this cycle
  assign res_load = out_free && ((state == S_EMIT) || (state == S_OVR) ||
                                 (state == S_TMO) || (state == S_DONE));
  assign c        = current[ix];
  assign busy     = (state != S_IDLE) || res_valid;
  assign pop      = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && res_stall);
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            op        <= head;
            used      <= (32'(slots_in_use) > SLOTS) ? CW'(SLOTS) : cfg_ext;
            idx       <= '0;
            dup       <= 1'b0;
            have_free <= 1'b0;
            free_idx  <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle; single-slot ops finish at once
          unique case (ptt_pkg::kind_t'(op.kind)) inside
            ptt_pkg::K_INSERT, ptt_pkg::K_LOOKUP, ptt_pkg::K_TICK: begin
              if (idx >= used) begin
                if (ptt_pkg::kind_t'(op.kind) == ptt_pkg::K_TICK) begin
                  state <= S_DONE;
                end else if (ptt_pkg::kind_t'(op.kind) == ptt_pkg::K_LOOKUP) begin
                  pend  <= '{ptt_pkg::R_NOTFOUND, 4'd0, op.event_id, 32'd0, 1'b1};
                  state <= S_EMIT;
                end else if (op.event_id == 16'd0 || dup || !have_free) begin
                  pend  <= '{ptt_pkg::R_INSFAIL, 4'd0, op.event_id, 32'd0, 1'b1};
                  state <= S_EMIT;
                end else begin
                  active[free_idx]  <= 1'b1;
                  owner[free_idx]   <= op.event_id;
                  reload[free_idx]  <= (op.count == 32'd0) ? 32'd1 : op.count;
                  current[free_idx] <= (op.count == 32'd0) ? 32'd1 : op.count;
                  ctxw[free_idx]    <= op.context_req;
                  pend  <= '{ptt_pkg::R_INSERTED, 4'(free_idx), op.event_id,
                             op.context_req, 1'b1};
                  state <= S_EMIT;
                end
              end else if (ptt_pkg::kind_t'(op.kind) == ptt_pkg::K_TICK) begin
                if (op.elapsed == 32'd0) begin
                  state <= S_DONE;
                end else begin
                  if (active[ix]) begin
                    if (c > op.elapsed) begin
                      current[ix] <= c - op.elapsed;
                    end else begin
                      current[ix] <= reload[ix];
                      state <= (c < op.elapsed) ? S_OVR : S_TMO;
                    end
                  end
                  idx <= idx + 1'b1;
                end
              end else if (ptt_pkg::kind_t'(op.kind) == ptt_pkg::K_LOOKUP) begin
                if (op.event_id != 16'd0 && active[ix] && owner[ix] == op.event_id) begin
                  pend  <= '{ptt_pkg::R_FOUND, 4'(ix), op.event_id, ctxw[ix], 1'b1};
                  state <= S_EMIT;
                end
                idx <= idx + 1'b1;
              end else begin
                if (active[ix] && owner[ix] == op.event_id) dup <= 1'b1;
                if (!active[ix] && !have_free) begin
                  have_free <= 1'b1;
                  free_idx  <= ix;
                end
                idx <= idx + 1'b1;
              end
            end
            ptt_pkg::K_DELETE: begin
              if (sok && active[sx]) begin
                active[sx] <= 1'b0;
                pend <= '{ptt_pkg::R_DELETED, op.slot, owner[sx], ctxw[sx], 1'b1};
              end else begin
                pend <= '{ptt_pkg::R_DONE, 4'd0, 16'd0, 32'd0, 1'b1};
              end
              state <= S_EMIT;
            end
            ptt_pkg::K_GETCTX: begin
              if (sok) pend <= '{ptt_pkg::R_CONTEXT, op.slot, owner[sx], ctxw[sx], 1'b1};
              else     pend <= '{ptt_pkg::R_CONTEXT, op.slot, 16'd0, 32'd0, 1'b1};
              state <= S_EMIT;
            end
            ptt_pkg::K_SETCNT, ptt_pkg::K_RSTCNT: begin
              if (sok) begin
                current[sx] <= (ptt_pkg::kind_t'(op.kind) == ptt_pkg::K_SETCNT) ?
                               op.count : reload[sx];
              end
              pend  <= '{ptt_pkg::R_DONE, op.slot, 16'd0, 32'd0, 1'b1};
              state <= S_EMIT;
            end
            default: begin
              pend  <= '{ptt_pkg::R_DONE, 4'd0, 16'd0, 32'd0, 1'b1};
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            res   <= pend;
            state <= S_IDLE;
          end
        end
        S_OVR: begin
          if (out_free) begin
            res <= '{ptt_pkg::R_OVERRUN, 4'(IW'(idx - 1'b1)), owner[IW'(idx - 1'b1)],
                     ctxw[IW'(idx - 1'b1)], 1'b0};
            state <= S_TMO;
          end
        end
        S_TMO: begin
          if (out_free) begin
            res <= '{ptt_pkg::R_TIMEOUT, 4'(IW'(idx - 1'b1)), owner[IW'(idx - 1'b1)],
                     ctxw[IW'(idx - 1'b1)], 1'b0};
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res   <= '{ptt_pkg::R_DONE, 4'd0, 16'd0, 32'd0, 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: periodic timer table unit testbench
// Directed then random operations across several slots_in_use settings, with
// idling on both channels; results checked in order against a scoreboard
// model of the timer table.
// ----------------------------------------------------------------------------

class timer_scoreboard;
  bit          active[16];
  bit          written[16];
  logic [15:0] owner[16];
  logic [31:0] reload[16];
  logic [31:0] current[16];
  logic [31:0] ctx[16];
  logic [4:0]  slots_cfg;
  ptt_pkg::result_t expected_q[$];
  int          errors;

  function new();
    slots_cfg = ptt_pkg::UseReset;
    errors = 0;
    for (int i = 0; i < 16; i++) begin
      active[i] = 0;
      written[i] = 0;
    end
  endfunction

  function int unsigned usable();
    return (slots_cfg > 16) ? 16 : slots_cfg;
  endfunction

  function void push(ptt_pkg::code_t c, int unsigned s, logic [15:0] id,
                     logic [31:0] cx);
    ptt_pkg::result_t r;
    r.code = c;
    r.slot_res = s[3:0];
    r.event_id_res = id;
    r.context_res = cx;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  // timer table behaviour for one accepted item
  function void note_item(ptt_pkg::item_t it);
    int unsigned used;
    int unsigned pick;
    bit          dup;
    bit          hit;
    bit          ok;
    logic [31:0] c;
    logic [31:0] cnt;
    used = usable();
    ok = it.slot < used;
    cnt = it.count;
    case (it.kind)
      ptt_pkg::K_INSERT: begin
        dup = 0;
        pick = used;
        for (int i = 0; i < used; i++)
          if (active[i] && owner[i] == it.event_id) dup = 1;
        if (it.event_id != 0 && !dup)
          for (int i = 0; i < used; i++)
            if (!active[i] && pick == used) pick = i;
        if (it.event_id == 0 || dup || pick >= used) begin
          push(ptt_pkg::R_INSFAIL, 0, it.event_id, 0);
        end else begin
          if (cnt == 0) cnt = 1;
          active[pick] = 1;
          written[pick] = 1;
          owner[pick] = it.event_id;
          reload[pick] = cnt;
          current[pick] = cnt;
          ctx[pick] = it.context_req;
          push(ptt_pkg::R_INSERTED, pick, it.event_id, it.context_req);
        end
      end
      ptt_pkg::K_DELETE: begin
        if (ok && active[it.slot]) begin
          active[it.slot] = 0;
          push(ptt_pkg::R_DELETED, it.slot, owner[it.slot], ctx[it.slot]);
        end else begin
          push(ptt_pkg::R_DONE, 0, 0, 0);
        end
      end
      ptt_pkg::K_TICK: begin
        if (it.elapsed != 0)
          for (int i = 0; i < used; i++) begin
            if (active[i]) begin
              c = current[i];
              if (c > it.elapsed) begin
                current[i] = c - it.elapsed;
              end else begin
                current[i] = reload[i];
                if (c < it.elapsed) push(ptt_pkg::R_OVERRUN, i, owner[i], ctx[i]);
                push(ptt_pkg::R_TIMEOUT, i, owner[i], ctx[i]);
              end
            end
          end
        push(ptt_pkg::R_DONE, 0, 0, 0);
      end
      ptt_pkg::K_LOOKUP: begin
        hit = 0;
        if (it.event_id != 0)
          for (int i = 0; i < used; i++)
            if (!hit && active[i] && owner[i] == it.event_id) begin
              push(ptt_pkg::R_FOUND, i, it.event_id, ctx[i]);
              hit = 1;
            end
        if (!hit) push(ptt_pkg::R_NOTFOUND, 0, it.event_id, 0);
      end
      ptt_pkg::K_GETCTX: begin
        if (ok) push(ptt_pkg::R_CONTEXT, it.slot, owner[it.slot], ctx[it.slot]);
        else push(ptt_pkg::R_CONTEXT, it.slot, 0, 0);
      end
      ptt_pkg::K_SETCNT: begin
        if (ok) current[it.slot] = cnt;
        push(ptt_pkg::R_DONE, it.slot, 0, 0);
      end
      ptt_pkg::K_RSTCNT: begin
        if (ok) current[it.slot] = reload[it.slot];
        push(ptt_pkg::R_DONE, it.slot, 0, 0);
      end
      default: push(ptt_pkg::R_DONE, 0, 0, 0);
    endcase
    expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  function void check_result(ptt_pkg::result_t got);
    ptt_pkg::result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.code !== want.code || got.slot_res !== want.slot_res ||
        got.event_id_res !== want.event_id_res ||
        got.context_res !== want.context_res || got.last !== want.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: exp code %0d slot %0d id %h ctx %h last %b",
                 want.code, want.slot_res, want.event_id_res, want.context_res,
                 want.last);
        $display("          got code %0d slot %0d id %h ctx %h last %b",
                 got.code, got.slot_res, got.event_id_res, got.context_res,
                 got.last);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int StallLimit = 5000;

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_stall;
  ptt_pkg::item_t   in_data = '0;
  logic             out_valid;
  logic             out_stall = 0;
  ptt_pkg::result_t out_data;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [ptt_pkg::CfgW-1:0] cfg_data = '0;

  timer_scoreboard  sb = new();
  int               tx_idle = 12;   // percent of items before which the sender holds off
  int               rx_idle = 53;   // percent of cycles the receiver stalls
  int               quiet_cycles = 0;

  always #5 clk = ~clk;

  periodic_timer_table_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle);

  // result monitor: pre-edge values are the transferred ones
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(ptt_pkg::item_t it);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_item(in_data);
  endtask

  // hold off until the table has answered everything outstanding
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_slots(logic [ptt_pkg::CfgW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.slots_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic ptt_pkg::item_t mk(ptt_pkg::kind_t k, logic [15:0] id,
                                        logic [3:0] s, logic [31:0] cnt,
                                        logic [31:0] el, logic [31:0] cx);
    ptt_pkg::item_t it;
    it.kind = k;
    it.event_id = id;
    it.slot = s;
    it.count = cnt;
    it.elapsed = el;
    it.context_req = cx;
    return it;
  endfunction

  // random item biased towards live timers: small id pool, short counts,
  // and ticks that often land exactly on a slot's remaining count
  function automatic ptt_pkg::item_t random_item();
    ptt_pkg::item_t it;
    int unsigned    w;
    int unsigned    s;
    it.kind = ptt_pkg::K_NONE;
    it.event_id = ($urandom_range(9) < 7) ? 16'($urandom_range(1, 6)) : 16'($urandom);
    if ($urandom_range(19) == 0) it.event_id = 0;
    it.slot = 4'($urandom_range(15));
    it.count = ($urandom_range(9) < 7) ? $urandom_range(0, 20) : $urandom;
    if ($urandom_range(19) == 0) it.count = 32'hFFFF_FFFF;
    it.elapsed = $urandom_range(0, 10);
    s = $urandom_range(15);
    if ($urandom_range(2) == 0 && sb.active[s]) it.elapsed = sb.current[s];
    if ($urandom_range(15) == 0) it.elapsed = $urandom;
    it.context_req = $urandom;
    w = $urandom_range(99);
    if (w < 25) it.kind = ptt_pkg::K_INSERT;
    else if (w < 50) it.kind = ptt_pkg::K_TICK;
    else if (w < 62) it.kind = ptt_pkg::K_LOOKUP;
    else if (w < 72) it.kind = ptt_pkg::K_DELETE;
    else if (w < 80) it.kind = ptt_pkg::K_GETCTX;
    else if (w < 88) it.kind = ptt_pkg::K_SETCNT;
    else if (w < 96) it.kind = ptt_pkg::K_RSTCNT;
    // never ask for the context of a usable slot whose contents were never written
    if (it.kind == ptt_pkg::K_GETCTX && it.slot < sb.usable() && !sb.written[it.slot])
      it.kind = ptt_pkg::K_LOOKUP;
    return it;
  endfunction

  logic [ptt_pkg::CfgW-1:0] settings[6] = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd3};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset value of slots_in_use (16) in force
    send(mk(ptt_pkg::K_INSERT, 16'd1, 4'd0, 32'd0, 32'd0, 32'h1111_0000)); // reload 0 -> 1
    send(mk(ptt_pkg::K_INSERT, 16'd0, 4'd0, 32'd5, 32'd0, 32'h0));         // id none
    send(mk(ptt_pkg::K_INSERT, 16'd1, 4'd0, 32'd5, 32'd0, 32'h0));         // duplicate
    send(mk(ptt_pkg::K_INSERT, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF));
    send(mk(ptt_pkg::K_INSERT, 16'd2, 4'd0, 32'd3, 32'd0, 32'h0));
    send(mk(ptt_pkg::K_LOOKUP, 16'd1, 4'd0, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_LOOKUP, 16'd0, 4'd0, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_LOOKUP, 16'd7, 4'd0, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_GETCTX, 16'd0, 4'd0, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_TICK, 16'd0, 4'd0, 32'd0, 32'd0, 32'd0));           // nothing moves
    send(mk(ptt_pkg::K_TICK, 16'd0, 4'd0, 32'd0, 32'd1, 32'd0));           // exact timeout
    send(mk(ptt_pkg::K_TICK, 16'd0, 4'd0, 32'd0, 32'd5, 32'd0));           // overruns
    send(mk(ptt_pkg::K_SETCNT, 16'd0, 4'd2, 32'd4, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_RSTCNT, 16'd0, 4'd2, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_SETCNT, 16'd0, 4'd15, 32'd9, 32'd0, 32'd0));        // free slot
    send(mk(ptt_pkg::K_DELETE, 16'd0, 4'd1, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_DELETE, 16'd0, 4'd1, 32'd0, 32'd0, 32'd0));         // already free
    send(mk(ptt_pkg::K_GETCTX, 16'd0, 4'd1, 32'd0, 32'd0, 32'd0));         // freed, still read
    send(mk(ptt_pkg::K_NONE, 16'd0, 4'd0, 32'd0, 32'd0, 32'd0));
    send(mk(ptt_pkg::K_TICK, 16'd0, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'd0));
    drain();   // sender waits for every outstanding result

    // random phases, one slots_in_use setting each
    for (int p = 0; p < 6; p++) begin
      write_slots(settings[p]);
      if (p == 2) begin
        tx_idle = 53;
        rx_idle = 12;
      end else if (p == 4) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      repeat (25) send(random_item());
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
